// ===== rtl/core/chr_pkg.sv =====
// package for the compacting handle registry
// holds table sizes, operation and status codes and the controller state type
// no dependencies

package chr_pkg;

  localparam int DEPTH    = 64;
  localparam int HANDLE_W = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam int IN_TDATA_W  = ((HANDLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((HANDLE_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_DRAINED  = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_SPARE    = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EMIT,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } state_t;

endpackage

// ===== rtl/core/compacting_handle_registry_top.sv =====
// compacting handle registry: packed table of nonzero handles in one memory, uses chr_pkg
// add/remove: one slot read per cycle, remove shifts later slots down one per cycle;
//   result loaded into the output register after the scan and any shift, once the output is free
// drain: reads the highest slot, then emits it, until empty; empty drain goes straight to emit
// next request accepted in the cycle after the last result of a request is loaded
// sync active-low reset clears fill count, controller and output valid, not the slot memory

module compacting_handle_registry_top
  import chr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] handle
  input  logic [1:0]             in_tuser,   // [1:0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] entry, [38:32] fill, zero pad
  output logic [2:0]             out_tuser,  // [2:0] status
  output logic                   out_tlast
);

  // slot memory, one read and one write port, registered read
  logic [HANDLE_W-1:0] mem [DEPTH];
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [HANDLE_W-1:0] wr_data;
  logic [HANDLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [HANDLE_W-1:0] h_r, h_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  status_t             res_status_r, res_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_entry_r, out_entry_nxt;
  logic [CNT_W-1:0]    out_fill_r, out_fill_nxt;
  logic                out_last_r, out_last_nxt;

  logic             in_acc;
  logic             out_free;
  logic             scan_hit;
  logic             scan_end;
  logic             more_slots;
  logic [CNT_W-1:0] occ_dec;
  op_t              in_op;
  logic [HANDLE_W-1:0] in_handle;

  assign in_op      = op_t'(in_tuser);
  assign in_handle  = in_tdata[HANDLE_W-1:0];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  // compare uses the registered read data, so it lags the read address
  assign scan_hit   = rd_vld_r && (rd_data_r == h_r);
  assign scan_end   = !rd_vld_r && (idx_r >= occ_r);
  assign more_slots = (idx_r < occ_r);
  assign occ_dec    = occ_r - CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_op == OP_ADD || in_op == OP_REMOVE) && in_handle != '0) begin
            state_nxt = S_SCAN;
          end else if (in_op == OP_DRAIN) begin
            state_nxt = (occ_r == '0) ? S_EMIT : S_DRAIN_RD;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = (op_r == OP_REMOVE) ? S_SHIFT : S_EMIT;
        end else if (scan_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (!rd_vld_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        state_nxt = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (out_free) begin
          state_nxt = (occ_dec == '0) ? S_IDLE : S_DRAIN_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt         = op_r;
    h_nxt          = h_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    wr_idx_nxt     = wr_idx_r;
    rd_vld_nxt     = 1'b0;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = wr_idx_r;
    wr_data        = rd_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_fill_nxt   = out_fill_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_op;
          h_nxt          = (in_op == OP_DRAIN) ? '0 : in_handle;
          idx_nxt        = '0;
          res_status_nxt = ST_EMPTY;
        end
      end
      S_SCAN: begin
        if (more_slots) begin
          rd_en       = 1'b1;
          rd_vld_nxt  = 1'b1;
          idx_nxt     = idx_r + CNT_W'(1);
          cmp_idx_nxt = idx_r[IDX_W-1:0];
        end
        if (scan_hit) begin
          res_status_nxt = ST_PRESENT;
          // the read in flight is the slot right after the hit
          wr_idx_nxt     = cmp_idx_r;
        end else if (scan_end) begin
          if (op_r == OP_ADD) begin
            if (occ_r == CNT_W'(DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = occ_r[IDX_W-1:0];
              wr_data        = h_r;
              occ_nxt        = occ_r + CNT_W'(1);
              res_status_nxt = ST_ADDED;
            end
          end else begin
            res_status_nxt = ST_NOTFOUND;
          end
        end
      end
      S_SHIFT: begin
        if (more_slots) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          // move the slot just read down by one
          wr_en      = 1'b1;
          wr_idx_nxt = wr_idx_r + IDX_W'(1);
        end else begin
          occ_nxt        = occ_dec;
          res_status_nxt = ST_REMOVED;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = h_r;
          out_fill_nxt   = occ_r;
          out_last_nxt   = 1'b1;
        end
      end
      S_DRAIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = occ_dec[IDX_W-1:0];
      end
      S_DRAIN_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DRAINED;
          out_entry_nxt  = rd_data_r;
          out_fill_nxt   = occ_dec;
          out_last_nxt   = (occ_dec == '0);
          occ_nxt        = occ_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    h_r          <= h_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_fill_r   <= out_fill_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_fill_r, out_entry_r});
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sim/compacting_handle_registry_top_tb.sv =====
// testbench for compacting_handle_registry_top: add, remove and drain requests on the stream
// ports, checked result by result against a packed-table predictor; depends on chr_pkg

module compacting_handle_registry_top_tb
  import chr_pkg::*;
();

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] entry;
    logic                last;
    logic [CNT_W-1:0]    fill;
  } reg_result_t;

  typedef struct {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    reg_result_t         res;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = OP_ADD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;

  logic [HANDLE_W-1:0] stored_handles[$];
  reg_result_t         pending_results[$];
  logic [HANDLE_W-1:0] handle_pool[0:31];
  int                  mismatches = 0;
  bit                  quiet = 1'b0;
  int                  stall_left = 0;

  compacting_handle_registry_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // packed table model; a typed row replaces the single computed result
  task automatic predict_request(input op_t op, input logic [HANDLE_W-1:0] h,
                                 input bit typed, input reg_result_t typed_res);
    int          pos;
    reg_result_t r;
    pos = -1;
    if (op == OP_NONE) return;
    if (op != OP_DRAIN && h == '0) return;
    for (int i = 0; i < stored_handles.size(); i++)
      if (pos < 0 && stored_handles[i] == h) pos = i;
    r.entry = h;
    r.last = 1'b1;
    case (op)
      OP_ADD: begin
        if (pos >= 0) begin
          r.status = ST_PRESENT;
        end else if (stored_handles.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stored_handles.push_back(h);
          r.status = ST_ADDED;
        end
      end
      OP_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          stored_handles.delete(pos);
          r.status = ST_REMOVED;
        end
      end
      default: begin
        if (stored_handles.size() == 0) begin
          r.status = ST_EMPTY;
          r.entry = '0;
        end else begin
          // highest slot first, last flag on the final one
          while (stored_handles.size() > 0) begin
            r.status = ST_DRAINED;
            r.entry = stored_handles.pop_back();
            r.last = (stored_handles.size() == 0);
            r.fill = CNT_W'(stored_handles.size());
            pending_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.fill = CNT_W'(stored_handles.size());
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // leaves in_tvalid high unless a gap follows; callers that pause lower it
  task automatic send_request(input op_t op, input logic [HANDLE_W-1:0] h,
                              input bit typed = 1'b0, input reg_result_t typed_res = '0);
    in_tuser <= op;
    in_tdata <= h;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_request(op, h, typed, typed_res);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver stalls in bursts, no new burst once the run goes quiet
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reg_result_t exp_res;
    reg_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.entry = out_tdata[HANDLE_W-1:0];
      got.last = out_tlast;
      got.fill = out_tdata[HANDLE_W +: CNT_W];
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d entry %h last %0d fill %0d",
                   got.status, got.entry, got.last, got.fill);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.status !== exp_res.status || got.entry !== exp_res.entry ||
            got.last !== exp_res.last || got.fill !== exp_res.fill) begin
          if (mismatches < 10)
            $display("mismatch: expected status %0d entry %h last %0d fill %0d, got %0d %h %0d %0d",
                     exp_res.status, exp_res.entry, exp_res.last, exp_res.fill,
                     got.status, got.entry, got.last, got.fill);
          mismatches++;
        end
      end
    end
  end

  initial begin
    row_t                directed[$];
    op_t                 op;
    logic [HANDLE_W-1:0] h;
    int                  pick;
    int                  counted;

    directed = '{
      '{OP_DRAIN,  32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 1'b1, 7'd0}},
      '{OP_REMOVE, 32'h0000_0005, 1'b1, '{ST_NOTFOUND, 32'h0000_0005, 1'b1, 7'd0}},
      '{OP_ADD,    32'h0000_0000, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_NONE,   32'h0000_0007, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_ADD,    32'hFFFF_FFFF, 1'b1, '{ST_ADDED,    32'hFFFF_FFFF, 1'b1, 7'd1}},
      '{OP_ADD,    32'h0000_0001, 1'b1, '{ST_ADDED,    32'h0000_0001, 1'b1, 7'd2}},
      '{OP_ADD,    32'hFFFF_FFFF, 1'b1, '{ST_PRESENT,  32'hFFFF_FFFF, 1'b1, 7'd2}},
      '{OP_REMOVE, 32'h0000_0000, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_NONE,   32'h0000_0000, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_ADD,    32'h8000_0000, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_ADD,    32'h5555_5555, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_ADD,    32'hAAAA_AAAA, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_REMOVE, 32'h0000_0001, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_REMOVE, 32'hAAAA_AAAA, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_REMOVE, 32'h1234_5678, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_ADD,    32'h0000_0002, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_DRAIN,  32'hDEAD_BEEF, 1'b0, '{ST_ADDED,    32'h0,         1'b0, 7'd0}},
      '{OP_DRAIN,  32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 1'b1, 7'd0}}
    };

    for (int i = 0; i < 32; i++) handle_pool[i] = $urandom | 32'h1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].op, directed[i].handle, directed[i].typed, directed[i].res);

    // fill to capacity, hit full, remove at both ends, drain the lot
    for (int i = 0; i < DEPTH; i++)
      send_request(OP_ADD, ($urandom & 32'hFFFF_FF00) | (i + 1));
    send_request(OP_ADD, 32'h0000_0000 | 32'hFFFF_FF80);
    send_request(OP_ADD, stored_handles[DEPTH/2]);
    send_request(OP_REMOVE, stored_handles[0]);
    send_request(OP_REMOVE, stored_handles[stored_handles.size()-1]);
    send_request(OP_DRAIN, $urandom);

    counted = 0;
    while (counted < 180) begin
      if (counted == 90) wait_drained();
      if (counted == 150) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 48) op = OP_ADD;
      else if (pick < 87) op = OP_REMOVE;
      else if (pick < 97) op = OP_DRAIN;
      else op = OP_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 65) h = handle_pool[$urandom_range(0, 31)];
      else if (pick < 95) h = $urandom;
      else h = '0;
      if (op == OP_DRAIN || (op != OP_NONE && h != '0)) counted++;
      send_request(op, h);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/chr_pkg.sv
rtl/core/compacting_handle_registry_top.sv
sim/compacting_handle_registry_top_tb.sv
